>>> sv/lzwcsd_pkg.sv
// Shared types and constants for the LZW code stream decoder.
// Used by lzwcsd_ctrl, lzwcsd_dpath and lzw_code_stream_decoder.
// No dependencies.
package lzwcsd_pkg;

    // Default code width; the top level carries it as a parameter.
    localparam int CODE_BITS_DEFAULT = 9;
    // Bytes packed into one output word (fixed by the output word layout).
    localparam int BYTES_PER_RESULT = 8;
    // First code that refers to an added dictionary entry.
    localparam int DICT_BASE = 256;

    typedef struct packed {
        logic [8:0] code;
        logic       starts_stream;
    } code_word_t;

    typedef struct packed {
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic [7:0] byte_4;
        logic [7:0] byte_5;
        logic [7:0] byte_6;
        logic [7:0] byte_7;
        logic [3:0] byte_count;
        logic       last_of_string;
    } bytes_word_t;

    // Controller to datapath commands (one per controller step).
    typedef struct packed {
        logic accept;    // input word taken this cycle
        logic rd_code;   // previous-code entry back, fetch code entry
        logic decide;    // code entry back, add entry, set up the walk
        logic walk;      // one prefix chain step
        logic finish;    // write the root byte
        logic emit_req;  // read one stack row
        logic emit_load; // load the output register
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic in_start;  // starts_stream of the offered word
        logic walk_more; // another chain step is needed
        logic out_free;  // output register can take a word
        logic last_row;  // remaining bytes fit in one word
    } status_t;

endpackage

>>> sv/lzwcsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the dictionary and the byte stack lanes. No dependencies.
module lzwcsd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/lzwcsd_ctrl.sv
// Sequencing state machine for the LZW code stream decoder.
// Depends on lzwcsd_pkg (cmd_t, status_t).
module lzwcsd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                code_valid,
    output logic                code_ready,
    input  lzwcsd_pkg::status_t status,
    output lzwcsd_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_CODE,
        S_DECIDE,
        S_WALK,
        S_FINISH,
        S_EMIT_REQ,
        S_EMIT_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   code_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (code_valid)
                begin
                    state_next = status.in_start ? S_FINISH : S_RD_CODE;
                end
            end
            S_RD_CODE:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE, S_WALK:
            begin
                state_next = status.walk_more ? S_WALK : S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_EMIT_REQ;
            end
            S_EMIT_REQ:
            begin
                state_next = S_EMIT_LOAD;
            end
            S_EMIT_LOAD:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_row ? S_IDLE : S_EMIT_REQ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            code_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            code_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign code_ready = code_ready_reg;

    always_comb
    begin
        cmd.accept    = code_ready_reg && code_valid;
        cmd.rd_code   = (state_reg == S_RD_CODE);
        cmd.decide    = (state_reg == S_DECIDE);
        cmd.walk      = (state_reg == S_WALK);
        cmd.finish    = (state_reg == S_FINISH);
        cmd.emit_req  = (state_reg == S_EMIT_REQ);
        cmd.emit_load = (state_reg == S_EMIT_LOAD) && status.out_free;
    end

endmodule

>>> sv/lzwcsd_dpath.sv
// Datapath of the LZW code stream decoder: dictionary RAM, byte stack lanes,
// chain walk registers and the output register.
// Depends on lzwcsd_pkg and lzwcsd_ram.
module lzwcsd_dpath #(
    parameter int CODE_BITS = lzwcsd_pkg::CODE_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lzwcsd_pkg::code_word_t  code_word,
    input  logic                    bytes_ready,
    output logic                    bytes_valid,
    output lzwcsd_pkg::bytes_word_t bytes_word,
    input  lzwcsd_pkg::cmd_t        cmd,
    output lzwcsd_pkg::status_t     status
);

    localparam int CB          = CODE_BITS;
    localparam int TABLE_DEPTH = (1 << CB) - lzwcsd_pkg::DICT_BASE;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int MAX_LEN     = TABLE_DEPTH + 1;
    localparam int BPR         = lzwcsd_pkg::BYTES_PER_RESULT;
    localparam int LANE_W      = $clog2(BPR);
    localparam int STACK_ROWS  = (MAX_LEN + BPR - 1) / BPR;
    localparam int ROW_W       = $clog2(STACK_ROWS);

    localparam logic [CB-1:0] BASE   = CB'(lzwcsd_pkg::DICT_BASE);
    localparam logic [CB:0]   BASE_N = (CB + 1)'(lzwcsd_pkg::DICT_BASE);
    localparam logic [CB-1:0] ONE    = CB'(1);
    localparam logic [CB-1:0] BPR_N  = CB'(BPR);

    typedef struct packed {
        logic [CB-1:0] prefix;
        logic [7:0]    last_byte;
        logic [7:0]    first_byte;
        logic [CB-1:0] length;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Control state
    logic [CB-1:0] prev_reg;
    logic [CB:0]   nfe_reg;
    logic          out_valid_reg;

    // Working registers
    logic [CB-1:0] code_reg;
    logic [7:0]    first_p_reg;
    logic [CB-1:0] len_p_reg;
    logic [CB-1:0] cur_reg;
    logic [CB-1:0] pos_reg;
    logic [CB-1:0] rem_reg;
    logic [ROW_W-1:0] row_reg;
    lzwcsd_pkg::bytes_word_t out_reg;
    lzwcsd_pkg::bytes_word_t out_next;

    // Dictionary RAM
    logic             tbl_rd_en;
    logic [CB-1:0]    tbl_rd_code;
    logic [IDX_W-1:0] tbl_rd_addr;
    logic             tbl_wr_en;
    logic [IDX_W-1:0] tbl_wr_addr;
    entry_t           tbl_wr_data;
    entry_t           tbl_rdata;
    logic [ENTRY_W-1:0] tbl_rd_bits;

    // Byte stack lanes
    logic          st_en;
    logic [CB-1:0] st_pos;
    logic [7:0]    st_byte;
    logic [ROW_W-1:0] st_row;
    logic [7:0]    lane_rdata [BPR];
    logic [7:0]    lane_byte [BPR];

    // Decode
    logic [CB-1:0] code_in;
    logic          code_is_entry;
    logic          prev_is_entry;
    logic [7:0]    first_c;
    logic [CB-1:0] len_c;
    logic          known;
    logic          full;
    logic [CB-1:0] add_len;
    logic [CB-1:0] dec_cur;
    logic [CB-1:0] dec_pos;
    logic [CB-1:0] dec_len;
    logic [CB-1:0] emit_n;

    assign code_in       = CB'(code_word.code);
    assign code_is_entry = (code_reg >= BASE);
    assign prev_is_entry = (prev_reg >= BASE);
    assign tbl_rdata     = entry_t'(tbl_rd_bits);
    assign first_c       = code_is_entry ? tbl_rdata.first_byte : code_reg[7:0];
    assign len_c         = code_is_entry ? tbl_rdata.length : ONE;
    assign known         = ({1'b0, code_reg} < nfe_reg);
    assign full          = nfe_reg[CB];
    assign add_len       = len_p_reg + ONE;

    // Unknown code: walk the new entry, its last byte goes straight to the stack
    always_comb
    begin
        dec_cur = code_reg;
        dec_pos = len_c;
        dec_len = len_c;
        if (!known)
        begin
            dec_cur = prev_reg;
            dec_pos = len_p_reg;
            dec_len = full ? len_p_reg : add_len;
        end
    end

    always_comb
    begin
        status.in_start  = code_word.starts_stream;
        status.out_free  = !out_valid_reg || bytes_ready;
        status.last_row  = (rem_reg <= BPR_N);
        if (cmd.walk)
        begin
            status.walk_more = (tbl_rdata.prefix >= BASE) && (pos_reg > CB'(2));
        end
        else
        begin
            status.walk_more = (dec_cur >= BASE) && (dec_pos > ONE);
        end
    end

    // Dictionary read port
    always_comb
    begin
        tbl_rd_code = prev_reg;
        if (cmd.rd_code)
        begin
            tbl_rd_code = code_reg;
        end
        else if (cmd.decide)
        begin
            tbl_rd_code = dec_cur;
        end
        else if (cmd.walk)
        begin
            tbl_rd_code = tbl_rdata.prefix;
        end
    end

    assign tbl_rd_en   = cmd.accept || cmd.rd_code
                         || ((cmd.decide || cmd.walk) && status.walk_more);
    assign tbl_rd_addr = IDX_W'(tbl_rd_code - BASE);

    // Dictionary write port: previous string plus one byte
    assign tbl_wr_en               = cmd.decide && !full;
    assign tbl_wr_addr             = IDX_W'(nfe_reg - BASE_N);
    assign tbl_wr_data.prefix      = prev_reg;
    assign tbl_wr_data.last_byte   = known ? first_c : first_p_reg;
    assign tbl_wr_data.first_byte  = first_p_reg;
    assign tbl_wr_data.length      = add_len;

    lzwcsd_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_dict (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_bits)
    );

    // Byte stack write: one byte a cycle, lane = pos mod BPR, row = pos / BPR
    always_comb
    begin
        st_en   = 1'b0;
        st_pos  = '0;
        st_byte = cur_reg[7:0];
        if (cmd.decide && !known && !full)
        begin
            st_en   = 1'b1;
            st_pos  = len_p_reg;
            st_byte = first_p_reg;
        end
        else if (cmd.walk)
        begin
            st_en   = 1'b1;
            st_pos  = pos_reg - ONE;
            st_byte = tbl_rdata.last_byte;
        end
        else if (cmd.finish)
        begin
            st_en   = 1'b1;
            st_pos  = '0;
            st_byte = cur_reg[7:0];
        end
    end

    assign st_row = ROW_W'(st_pos >> LANE_W);

    for (genvar j = 0; j < BPR; j++)
    begin : g_lane
        lzwcsd_ram #(
            .WIDTH(8),
            .DEPTH(STACK_ROWS)
        ) u_lane (
            .clk     (clk),
            .wr_en   (st_en && (st_pos[LANE_W-1:0] == LANE_W'(j))),
            .wr_addr (st_row),
            .wr_data (st_byte),
            .rd_en   (cmd.emit_req),
            .rd_addr (row_reg),
            .rd_data (lane_rdata[j])
        );
    end

    // Output packing; bytes past the count read as zero
    assign emit_n = (rem_reg > BPR_N) ? BPR_N : rem_reg;

    always_comb
    begin
        for (int j = 0; j < BPR; j++)
        begin
            lane_byte[j] = (CB'(j) < emit_n) ? lane_rdata[j] : 8'h00;
        end
        out_next.byte_0         = lane_byte[0];
        out_next.byte_1         = lane_byte[1];
        out_next.byte_2         = lane_byte[2];
        out_next.byte_3         = lane_byte[3];
        out_next.byte_4         = lane_byte[4];
        out_next.byte_5         = lane_byte[5];
        out_next.byte_6         = lane_byte[6];
        out_next.byte_7         = lane_byte[7];
        out_next.byte_count     = 4'(emit_n);
        out_next.last_of_string = status.last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            nfe_reg       <= BASE_N;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.emit_load || (out_valid_reg && !bytes_ready);
            if (cmd.accept && code_word.starts_stream)
            begin
                nfe_reg  <= BASE_N;
                prev_reg <= CB'(code_in[7:0]);
            end
            else if (cmd.decide)
            begin
                if (!full)
                begin
                    nfe_reg <= nfe_reg + (CB + 1)'(1);
                end
                if (known)
                begin
                    prev_reg <= code_reg;
                end
                else if (!full)
                begin
                    prev_reg <= nfe_reg[CB-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            code_reg <= code_in;
            row_reg  <= '0;
            if (code_word.starts_stream)
            begin
                cur_reg <= CB'(code_in[7:0]);
                pos_reg <= ONE;
                rem_reg <= ONE;
            end
        end
        if (cmd.rd_code)
        begin
            first_p_reg <= prev_is_entry ? tbl_rdata.first_byte : prev_reg[7:0];
            len_p_reg   <= prev_is_entry ? tbl_rdata.length : ONE;
        end
        if (cmd.decide)
        begin
            cur_reg <= dec_cur;
            pos_reg <= dec_pos;
            rem_reg <= dec_len;
        end
        if (cmd.walk)
        begin
            cur_reg <= tbl_rdata.prefix;
            pos_reg <= pos_reg - ONE;
        end
        if (cmd.emit_load)
        begin
            out_reg <= out_next;
            rem_reg <= rem_reg - emit_n;
            row_reg <= row_reg + ROW_W'(1);
        end
    end

    assign bytes_valid = out_valid_reg;
    assign bytes_word  = out_reg;

endmodule

>>> sv/lzw_code_stream_decoder.sv
// Top level of the LZW code stream decoder.
// Depends on lzwcsd_pkg, lzwcsd_ctrl, lzwcsd_dpath (and lzwcsd_ram below it).
//
// Usage:
//  - code channel (code_valid/code_ready/code_word): one code per word, with
//    starts_stream set on the first code of a stream; that clears the added
//    dictionary entries and the code is taken as a single byte.
//  - bytes channel (bytes_valid/bytes_ready/bytes_word): the decoded string,
//    up to eight bytes per word in stream order, byte_count valid bytes, the
//    rest zero; last_of_string marks the final word for a code.
//  - One code at a time: a code of string length L walks its prefix chain in
//    the dictionary RAM one entry per cycle (registered read feeding the next
//    address), then unloads the byte stack one row of eight per output word.
//  - The final word of a code waits in the output register while the next
//    code is taken and walked; a stalled receiver holds the block only when
//    another word is ready to load.
//  - Reset: dictionary empty of added entries, previous code 0, code port
//    ready straight away. No clearing pass: RAM contents are only used for
//    entries written since reset or the last stream start.
module lzw_code_stream_decoder #(
    parameter int CODE_BITS = lzwcsd_pkg::CODE_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    code_valid,
    output logic                    code_ready,
    input  lzwcsd_pkg::code_word_t  code_word,
    output logic                    bytes_valid,
    input  logic                    bytes_ready,
    output lzwcsd_pkg::bytes_word_t bytes_word
);

    lzwcsd_pkg::cmd_t    cmd;
    lzwcsd_pkg::status_t status;

    // Sequencer: accept, look up, add, walk, unload
    lzwcsd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Dictionary, byte stack and output register
    lzwcsd_dpath #(
        .CODE_BITS(CODE_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .code_word   (code_word),
        .bytes_ready (bytes_ready),
        .bytes_valid (bytes_valid),
        .bytes_word  (bytes_word),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

>>> dv/lzwcsd_checker.sv
// Checker for the LZW code stream decoder: watches both channels, predicts the
// decoded byte words and compares them as they arrive.
// Depends on lzwcsd_pkg.
module lzwcsd_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    code_valid,
    input  logic                    code_ready,
    input  lzwcsd_pkg::code_word_t  code_word,
    input  logic                    bytes_valid,
    input  logic                    bytes_ready,
    input  lzwcsd_pkg::bytes_word_t bytes_word,
    output int                      errors,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DICT_BASE        = lzwcsd_pkg::DICT_BASE;
    localparam int BYTES_PER_RESULT = lzwcsd_pkg::BYTES_PER_RESULT;
    localparam int CODE_SPACE = 512;
    localparam int MAX_STRING = CODE_SPACE - DICT_BASE + 1;
    localparam int WORD_BITS  = $bits(lzwcsd_pkg::bytes_word_t);

    // Added dictionary entries, indexed by code - 256
    logic [8:0]  dict_prefix [256];
    logic [7:0]  dict_last   [256];
    logic [7:0]  dict_first  [256];
    int unsigned dict_len    [256];
    int unsigned free_slot;
    logic [8:0]  prior_code;
    logic [7:0]  string_buf  [MAX_STRING];

    lzwcsd_pkg::bytes_word_t expected_words [$];
    int unsigned words_seen;

    function automatic logic [7:0] head_byte(input logic [8:0] c);
        return (c < DICT_BASE) ? c[7:0] : dict_first[c[7:0]];
    endfunction

    function automatic int unsigned string_length(input logic [8:0] c);
        return (c < DICT_BASE) ? 1 : dict_len[c[7:0]];
    endfunction

    task automatic add_string(input logic [8:0] prefix, input logic [7:0] tail);
        int unsigned len;
        int unsigned slot;
        if (free_slot >= CODE_SPACE)
            return;
        slot = free_slot - DICT_BASE;
        len  = string_length(prefix) + 1;
        if (len > MAX_STRING)
            len = MAX_STRING;
        dict_prefix[slot] = prefix;
        dict_last[slot]   = tail;
        dict_first[slot]  = head_byte(prefix);
        dict_len[slot]    = len;
        free_slot++;
    endtask

    // Unwind the prefix chain of c and queue its bytes, eight per word.
    task automatic push_string(input logic [8:0] c);
        int unsigned len;
        int unsigned pos;
        int unsigned done;
        int unsigned n;
        logic [8:0]  walk;
        logic [7:0]  b [8];
        lzwcsd_pkg::bytes_word_t w;
        len = string_length(c);
        if (len < 1)
            len = 1;
        if (len > MAX_STRING)
            len = MAX_STRING;
        pos  = len;
        walk = c;
        while (walk >= DICT_BASE && pos > 1)
        begin
            pos--;
            string_buf[pos] = dict_last[walk[7:0]];
            walk = dict_prefix[walk[7:0]];
        end
        string_buf[0] = walk[7:0];
        done = 0;
        while (done < len)
        begin
            n = (len - done > BYTES_PER_RESULT) ? BYTES_PER_RESULT : len - done;
            for (int j = 0; j < BYTES_PER_RESULT; j++)
                b[j] = (j < n) ? string_buf[done + j] : 8'h00;
            done += n;
            w = '{b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7], 4'(n), done >= len};
            expected_words.push_back(w);
        end
    endtask

    task automatic predict_code(input lzwcsd_pkg::code_word_t cw);
        logic [8:0]  c;
        int unsigned target;
        c = cw.code;
        if (cw.starts_stream)
        begin
            // new stream: added entries dropped, code read as a plain byte
            free_slot  = DICT_BASE;
            prior_code = {1'b0, c[7:0]};
            push_string(prior_code);
        end
        else if (c < free_slot)
        begin
            add_string(prior_code, head_byte(c));
            prior_code = c;
            push_string(c);
        end
        else
        begin
            // not yet in the dictionary: previous string plus its own first byte
            target = free_slot;
            add_string(prior_code, head_byte(prior_code));
            if (target < CODE_SPACE)
                prior_code = target[8:0];
            push_string(prior_code);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] bytes mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_word(input lzwcsd_pkg::bytes_word_t got);
        lzwcsd_pkg::bytes_word_t want;
        if (expected_words.size() == 0)
            report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
        else
        begin
            want = expected_words.pop_front();
            for (int k = 0; k < BYTES_PER_RESULT; k++)
                if (got[WORD_BITS-1-8*k -: 8] !== want[WORD_BITS-1-8*k -: 8])
                    report_mismatch($sformatf("word %0d byte_%0d: expected %02h, got %02h",
                        words_seen, k, want[WORD_BITS-1-8*k -: 8],
                        got[WORD_BITS-1-8*k -: 8]));
            if (got.byte_count !== want.byte_count)
                report_mismatch($sformatf("word %0d byte_count: expected %0d, got %0d",
                    words_seen, want.byte_count, got.byte_count));
            if (got.last_of_string !== want.last_of_string)
                report_mismatch($sformatf("word %0d last_of_string: expected %0b, got %0b",
                    words_seen, want.last_of_string, got.last_of_string));
        end
        words_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_slot  = DICT_BASE;
            prior_code = '0;
            expected_words.delete();
            words_seen = 0;
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            if (code_valid && code_ready)
                predict_code(code_word);
            if (bytes_valid && bytes_ready)
                check_word(bytes_word);
            pending = expected_words.size();
        end
    end

endmodule

>>> dv/testbench.sv
// Top of the LZW decoder testbench: clock, reset, code word stimulus, receiver
// stalls, watchdog and verdict.
// Depends on lzwcsd_pkg, lzw_code_stream_decoder and lzwcsd_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 280;
    localparam int IDLE_LIMIT   = 4000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 60;

    logic                    clk;
    logic                    rst_n       = 1'b0;
    logic                    code_valid  = 1'b0;
    logic                    code_ready;
    lzwcsd_pkg::code_word_t  code_word   = '0;
    logic                    bytes_valid;
    logic                    bytes_ready = 1'b0;
    lzwcsd_pkg::bytes_word_t bytes_word;
    int                      errors;
    int                      pending;

    // Mirror of the next free dictionary slot, so that stimulus can aim at
    // known codes, the code just about to be added, and codes past it.
    int free_mirror = 256;
    int burst_left  = 0;
    int sent_count  = 0;
    int hold_left   = 0;
    int idle_cycles = 0;

    // Directed words, in order:
    //  - codes with no stream start after reset (previous code is 0)
    //  - a code well beyond the next free slot
    //  - stream start on byte 0, then byte 255
    //  - the code being added right now, twice running (string grows by one)
    //  - known added codes
    //  - stream start on a code of 256 or more (read as code mod 256)
    //  - alternating bit patterns on the code
    lzwcsd_pkg::code_word_t directed_words [16] = '{
        '{9'd65,  1'b0}, '{9'd256, 1'b0}, '{9'd511, 1'b0},
        '{9'd0,   1'b1}, '{9'd255, 1'b0}, '{9'd257, 1'b0}, '{9'd258, 1'b0},
        '{9'd256, 1'b0}, '{9'd259, 1'b0},
        '{9'd300, 1'b1}, '{9'd300, 1'b0},
        '{9'd511, 1'b1}, '{9'h0aa, 1'b0}, '{9'h155, 1'b0}, '{9'h0aa, 1'b1},
        '{9'h155, 1'b0}
    };

    lzw_code_stream_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .code_valid  (code_valid),
        .code_ready  (code_ready),
        .code_word   (code_word),
        .bytes_valid (bytes_valid),
        .bytes_ready (bytes_ready),
        .bytes_word  (bytes_word)
    );

    lzwcsd_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .code_valid  (code_valid),
        .code_ready  (code_ready),
        .code_word   (code_word),
        .bytes_valid (bytes_valid),
        .bytes_ready (bytes_ready),
        .bytes_word  (bytes_word),
        .errors      (errors),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one code word. The sender runs in bursts; between bursts valid
    // drops for a random gap (sometimes none, so bursts run back to back).
    // Called and returns at a falling edge.
    task automatic offer(input logic [8:0] c, input logic start);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                code_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        code_word  <= '{code: c, starts_stream: start};
        code_valid <= 1'b1;
        do
            @(posedge clk);
        while (!code_ready);
        @(negedge clk);
        // every code but a stream start adds an entry until the table is full
        if (start)
            free_mirror = 256;
        else if (free_mirror < 512)
            free_mirror++;
        sent_count++;
    endtask

    // Code for the middle of a stream: mostly the next free code or recent
    // entries (long prefix chains), some plain bytes, some codes past the
    // next free slot, the rest any known code.
    function automatic logic [8:0] pick_code(input int grow_pct);
        int r;
        int lo;
        r = $urandom_range(0, 99);
        if (r < grow_pct && free_mirror < 512)
            return free_mirror[8:0];
        if (r < grow_pct + 40 && free_mirror > 256)
        begin
            lo = (free_mirror - 12 > 256) ? free_mirror - 12 : 256;
            return 9'($urandom_range(lo, free_mirror - 1));
        end
        if (r < grow_pct + 65)
            return 9'($urandom_range(0, 255));
        if (r < grow_pct + 72 && free_mirror < 511)
            return 9'($urandom_range(free_mirror + 1, 511));
        return 9'($urandom_range(0, free_mirror - 1));
    endfunction

    // A stream: start word, then codes; now and then a stray start word
    // breaks the stream.
    task automatic send_stream(input int n_codes, input int grow_pct);
        if ($urandom_range(0, 9) == 0)
            offer(9'($urandom_range(256, 511)), 1'b1);
        else
            offer(9'($urandom_range(0, 255)), 1'b1);
        for (int i = 1; i < n_codes; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                offer(9'($urandom()), 1'b1);
            else
                offer(pick_code(grow_pct), 1'b0);
        end
    endtask

    // Receiver: ready in runs of random length, stalls mostly short with
    // the odd long one.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
                hold_left--;
            else if (bytes_ready && $urandom_range(0, 4) != 0)
            begin
                bytes_ready <= 1'b0;
                hold_left = ($urandom_range(0, 19) == 0) ? 24 : $urandom_range(0, 5);
            end
            else
            begin
                bytes_ready <= 1'b1;
                hold_left = $urandom_range(0, 20);
            end
        end
    end

    // Watchdog: too long with nothing accepted on either channel.
    always @(posedge clk)
    begin
        if ((code_valid && code_ready) || (bytes_valid && bytes_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int base;
        int stream_no;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_words[i])
            offer(directed_words[i].code, directed_words[i].starts_stream);

        // Random streams, mostly short; the third one is long enough to fill
        // the dictionary and leans hard on growing strings.
        base      = sent_count;
        stream_no = 0;
        while (sent_count - base < RANDOM_WORDS)
        begin
            if (stream_no == 2)
                send_stream(262, 45);
            else
                send_stream($urandom_range(3, 30), 15);
            stream_no++;
        end
        code_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
